### design/c3bc_pkg.sv
package c3bc_pkg;

  localparam int PIX_W    = 8;
  localparam int WIN_TAPS = 9;
  localparam int WIN_COLS = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_TAPS-1:0] win_t;

  localparam pix_t PIX_MAX = 8'd255;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IMG_W_REG_W = 11;
  localparam int IMG_H_REG_W = 13;
  localparam int COEF_REG_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MIDDLE  = 3'd3,
    REG_COEF_BOTTOM  = 3'd4
  } cfg_reg_e;

  localparam logic [IMG_W_REG_W-1:0] IMG_W_RESET  = 11'd1024;
  localparam logic [IMG_H_REG_W-1:0] IMG_H_RESET  = 13'd1024;
  localparam logic [COEF_REG_W-1:0]  COEF_TOP_RESET = 24'h000000;
  localparam logic [COEF_REG_W-1:0]  COEF_MID_RESET = 24'h001000;
  localparam logic [COEF_REG_W-1:0]  COEF_BOT_RESET = 24'h000000;

  typedef struct packed {
    logic [COEF_REG_W-1:0] bottom;
    logic [COEF_REG_W-1:0] middle;
    logic [COEF_REG_W-1:0] top;
  } coef_t;

  // Q4.4 datapath widths
  localparam int COEF_W   = 8;
  localparam int PROD_W   = 16;
  localparam int ROWSUM_W = 18;
  localparam int SUM_W    = 20;
  localparam int FRAC_W   = 4;

  localparam int RES_FIFO_DEPTH = 4;

endpackage

### design/c3bc_if.sv
interface c3bc_pix_if import c3bc_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c3bc_res_if import c3bc_pkg::*; #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
) ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  pix_t             pixel_out;
  logic             last_of_run;

  modport source (output valid, output out_col, output out_row, output pixel_out,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_col, input out_row, input pixel_out,
                  input last_of_run, output ready);
endinterface

interface c3bc_cfg_if import c3bc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/conv3x3_border_copy_clamp_unit.sv
// 3x3 convolution over a raster pixel stream, border pixels copied, result clamped.
//
// pix_i carries one 8-bit pixel per transfer in raster order; the unit counts
// column and row itself. res_o carries results with their column, row and a
// last_of_run mark; one pixel causes zero, one or two results (interior result of
// (x-1,y-1) first, then the pass-through of a border pixel). cfg_i writes the
// frame size and the three rows of signed Q4.4 coefficients by register index;
// it is always ready. The user must write it only while no pixel is in flight;
// the block itself does not enforce this. A result passes the pipeline stages
// (RAM read, window, products, row sums) and the result queue to reach res_o.
// Throughput: one pixel per cycle while the queue has room, set by one read and
// one write of the dual-port line RAM per pixel; a bottom-row or right-column
// pixel with x,y >= 2 yields two results, so input is throttled to one result per cycle.
// Stall: results wait in a 4-entry queue; pix_i.ready drops while it holds three
// or more, and the whole pipeline holds until the receiver drains it.
// Reset: column/row counters zero, registers to their defaults (identity kernel,
// 1024x1024), queue empty. The line RAM is not cleared; the first two rows of a
// frame only write it.
module conv3x3_border_copy_clamp_unit import c3bc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic       clk_i,
  input logic       rst_ni,
  c3bc_pix_if.sink  pix_i,
  c3bc_res_if.source res_o,
  c3bc_cfg_if.sink  cfg_i
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WMAX_W  = $clog2(MAX_WIDTH + 1);
  localparam int HMAX_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WEFF_W  = (IMG_W_REG_W > WMAX_W) ? IMG_W_REG_W : WMAX_W;
  localparam int HEFF_W  = (IMG_H_REG_W > HMAX_W) ? IMG_H_REG_W : HMAX_W;
  localparam int NSTAGE  = 4;

  typedef struct packed {
    logic             interior;
    logic             border;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pix_t             pix;
  } side_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pix_t             pix;
    logic             last;
  } res_t;

  // configuration
  logic [IMG_W_REG_W-1:0] img_w_q;
  logic [IMG_H_REG_W-1:0] img_h_q;
  coef_t                  coef_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q       <= IMG_W_RESET;
      img_h_q       <= IMG_H_RESET;
      coef_q.top    <= COEF_TOP_RESET;
      coef_q.middle <= COEF_MID_RESET;
      coef_q.bottom <= COEF_BOT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  img_w_q       <= cfg_i.data[IMG_W_REG_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q       <= cfg_i.data[IMG_H_REG_W-1:0];
        REG_COEF_TOP:     coef_q.top    <= cfg_i.data[COEF_REG_W-1:0];
        REG_COEF_MIDDLE:  coef_q.middle <= cfg_i.data[COEF_REG_W-1:0];
        REG_COEF_BOTTOM:  coef_q.bottom <= cfg_i.data[COEF_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero reads as one, saturate at the maximum
  logic [WEFF_W-1:0] w_eff;
  logic [HEFF_W-1:0] h_eff;

  always_comb begin
    priority if (img_w_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (WEFF_W'(img_w_q) > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(img_w_q);
    end
    priority if (img_h_q == '0) begin
      h_eff = HEFF_W'(1);
    end else if (HEFF_W'(img_h_q) > HEFF_W'(MAX_HEIGHT)) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(img_h_q);
    end
  end

  // position counters
  logic [COL_W-1:0]  x_q, x_d;
  logic [ROW_W-1:0]  y_q, y_d;
  logic [WEFF_W:0]   x_plus1;
  logic [HEFF_W:0]   y_plus1;
  logic              x_last, y_last;
  logic              adv, acc;
  side_t             side_d;

  assign x_plus1 = (WEFF_W+1)'(x_q) + (WEFF_W+1)'(1);
  assign y_plus1 = (HEFF_W+1)'(y_q) + (HEFF_W+1)'(1);
  assign x_last  = x_plus1 >= {1'b0, w_eff};
  assign y_last  = y_plus1 >= {1'b0, h_eff};

  assign acc         = pix_i.valid && adv;
  assign pix_i.ready = adv;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (x_last) begin
      x_d = '0;
      y_d = y_last ? '0 : y_q + ROW_W'(1);
    end else begin
      x_d = x_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (acc) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign side_d.interior = (x_q >= COL_W'(2)) && (y_q >= ROW_W'(2));
  assign side_d.border   = (x_q == '0) || x_last || (y_q == '0) || y_last;
  assign side_d.col      = x_q;
  assign side_d.row      = y_q;
  assign side_d.pix      = pix_i.pixel_in;

  // stage 0: RAM read, 1: window, 2: products, 3: row sums
  logic [NSTAGE-1:0] valid_q;
  side_t             side_q [NSTAGE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NSTAGE-2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NSTAGE; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  win_t win;
  pix_t mac_pix;

  c3bc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .acc_i     (acc),
    .acc_col_i (x_q),
    .a_valid_i (valid_q[0]),
    .a_col_i   (side_q[0].col),
    .a_pix_i   (side_q[0].pix),
    .win_o     (win)
  );

  c3bc_mac u_mac (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .win_i  (win),
    .coef_i (coef_q),
    .pix_o  (mac_pix)
  );

  // result assembly into the output queue
  side_t tail;
  res_t  res0, res1, res_out;
  logic  push0, push1;

  assign tail  = side_q[NSTAGE-1];
  assign push0 = adv && valid_q[NSTAGE-1] && (tail.interior || tail.border);
  assign push1 = adv && valid_q[NSTAGE-1] && tail.interior && tail.border;

  always_comb begin
    res1.col  = tail.col;
    res1.row  = tail.row;
    res1.pix  = tail.pix;
    res1.last = 1'b1;
    if (tail.interior) begin
      res0.col  = tail.col - COL_W'(1);
      res0.row  = tail.row - ROW_W'(1);
      res0.pix  = mac_pix;
      res0.last = !tail.border;
    end else begin
      res0 = res1;
    end
  end

  c3bc_res_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .data0_i (res0),
    .push1_i (push1),
    .data1_i (res1),
    .free2_o (adv),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_out)
  );

  assign res_o.out_col     = res_out.col;
  assign res_o.out_row     = res_out.row;
  assign res_o.pixel_out   = res_out.pix;
  assign res_o.last_of_run = res_out.last;

endmodule

### design/c3bc_ram.sv
module c3bc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/c3bc_window.sv
module c3bc_window import c3bc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             acc_i,
  input  logic [COL_W-1:0] acc_col_i,
  input  logic             a_valid_i,
  input  logic [COL_W-1:0] a_col_i,
  input  pix_t             a_pix_i,
  output win_t             win_o
);

  localparam int PAIR_W = 2 * PIX_W;

  // one entry holds {row y-2, row y-1} for a column
  logic [PAIR_W-1:0] rd_data;
  logic [PAIR_W-1:0] line_rd;
  logic [PAIR_W-1:0] wr_data;
  logic [PAIR_W-1:0] fwd_data_q;
  logic              fwd_q;
  logic              we;
  pix_t              up2;
  pix_t              up1;
  win_t              win_q;

  assign we      = adv_i && a_valid_i;
  assign line_rd = fwd_q ? fwd_data_q : rd_data;
  assign up2     = line_rd[PAIR_W-1:PIX_W];
  assign up1     = line_rd[PIX_W-1:0];
  assign wr_data = {up1, a_pix_i};

  c3bc_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (a_col_i),
    .wdata_i (wr_data),
    .re_i    (acc_i),
    .raddr_i (acc_col_i),
    .rdata_o (rd_data)
  );

  // read and write of the same column in one cycle (width of one): bypass the RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (acc_i) begin
      fwd_q <= we && (acc_col_i == a_col_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (we) begin
      for (int r = 0; r < WIN_COLS; r++) begin
        win_q[r*WIN_COLS]     <= win_q[r*WIN_COLS + 1];
        win_q[r*WIN_COLS + 1] <= win_q[r*WIN_COLS + 2];
      end
      win_q[2] <= up2;
      win_q[5] <= up1;
      win_q[8] <= a_pix_i;
    end
  end

  assign win_o = win_q;

endmodule

### design/c3bc_mac.sv
module c3bc_mac import c3bc_pkg::*; (
  input  logic  clk_i,
  input  logic  adv_i,
  input  win_t  win_i,
  input  coef_t coef_i,
  output pix_t  pix_o
);

  logic [COEF_REG_W-1:0]      crow      [WIN_COLS];
  logic signed [COEF_W-1:0]   cf        [WIN_TAPS];
  logic signed [PROD_W:0]     prod_full [WIN_TAPS];
  logic signed [PROD_W-1:0]   prod_q    [WIN_TAPS];
  logic signed [ROWSUM_W-1:0] rs_d      [WIN_COLS];
  logic signed [ROWSUM_W-1:0] rs_q      [WIN_COLS];
  logic signed [SUM_W-1:0]    total;
  logic [SUM_W-FRAC_W-1:0]    whole;

  assign crow[0] = coef_i.top;
  assign crow[1] = coef_i.middle;
  assign crow[2] = coef_i.bottom;

  always_comb begin
    for (int r = 0; r < WIN_COLS; r++) begin
      for (int c = 0; c < WIN_COLS; c++) begin
        cf[r*WIN_COLS + c] = signed'(crow[r][COEF_W*c +: COEF_W]);
      end
    end
    for (int i = 0; i < WIN_TAPS; i++) begin
      prod_full[i] = $signed({1'b0, win_i[i]}) * cf[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        prod_q[i] <= prod_full[i][PROD_W-1:0];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < WIN_COLS; r++) begin
      rs_d[r] = ROWSUM_W'(prod_q[r*WIN_COLS]) + ROWSUM_W'(prod_q[r*WIN_COLS + 1])
              + ROWSUM_W'(prod_q[r*WIN_COLS + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rs_q <= rs_d;
    end
  end

  assign total = SUM_W'(rs_q[0]) + SUM_W'(rs_q[1]) + SUM_W'(rs_q[2]);
  assign whole = total[SUM_W-1:FRAC_W];

  // negative -> 0, floor, saturate at 255
  always_comb begin
    priority if (total[SUM_W-1]) begin
      pix_o = '0;
    end else if (whole > (SUM_W-FRAC_W)'(PIX_MAX)) begin
      pix_o = PIX_MAX;
    end else begin
      pix_o = whole[PIX_W-1:0];
    end
  end

endmodule

### design/c3bc_res_fifo.sv
module c3bc_res_fifo import c3bc_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic             push1_i,
  input  logic [WIDTH-1:0] data1_i,
  output logic             free2_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wptr_nx;
  logic             pop;
  logic [1:0]       n_push;

  // push1 is only raised together with push0
  assign n_push  = {1'b0, push0_i} + {1'b0, push1_i};
  assign pop     = valid_o && ready_i;
  assign wptr_nx = wptr_q + PTR_W'(1);
  assign wptr_d  = wptr_q + PTR_W'(n_push);
  assign rptr_d  = rptr_q + PTR_W'(pop);
  assign count_d = count_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem[wptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem[wptr_nx] <= data1_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem[rptr_q];
  assign free2_o = (count_q <= CNT_W'(RES_FIFO_DEPTH - 2));

endmodule

### design/c3bc_checker.sv
module c3bc_checker import c3bc_pkg::*; #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [COL_W-1:0] out_col_i,
  input logic [ROW_W-1:0] out_row_i,
  input pix_t             out_pix_i,
  input logic             out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_col_i)
      && $stable(out_row_i) && $stable(out_pix_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // top row results are pass-through only, so always end their run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_row_i == '0) |-> out_last_i)
    else $error("top row result without last_of_run");

  // first of a pair is followed at once by the closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_last_i)
    else $error("pair not completed");

  // input backpressure only comes from queued results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

endmodule

bind conv3x3_border_copy_clamp_unit c3bc_checker #(
  .COL_W (COL_W),
  .ROW_W (ROW_W)
) u_c3bc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_col_i   (res_o.out_col),
  .out_row_i   (res_o.out_row),
  .out_pix_i   (res_o.pixel_out),
  .out_last_i  (res_o.last_of_run)
);

### sim/conv3x3_border_copy_clamp_unit_tb.sv
`timescale 1ns / 1ps

module conv3x3_border_copy_clamp_unit_tb;
  import c3bc_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    pix_t        pix;
    logic        last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  c3bc_pix_if pix_if ();
  c3bc_res_if res_if ();
  c3bc_cfg_if cfg_if ();

  conv3x3_border_copy_clamp_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // expected pixels in transfer order
  result_t pending_results[$];
  int n_errors = 0;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;

  // shadow of the block's registers and state
  logic [IMG_W_REG_W-1:0] width_reg;
  logic [IMG_H_REG_W-1:0] height_reg;
  logic [COEF_REG_W-1:0]  kernel_rows [3];  // top, middle, bottom
  pix_t                   line_old [MAX_W];
  pix_t                   line_new [MAX_W];
  logic [1:0]             col_hits [MAX_W];  // saturating write count per column
  pix_t                   window [9];
  int unsigned            col_cnt;
  int unsigned            row_cnt;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned clip_size(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // true when every column below w has been written at least twice
  function automatic bit columns_filled(input int unsigned w);
    for (int i = 0; i < w; i++) begin
      if (col_hits[i] != 2'd2) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(6))
      0: return '0;
      1: return PIX_MAX;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned rand_size(input int unsigned big_lo,
                                            input int unsigned big_hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(2);
    if (pick < 70) return $urandom_range(3, 8);
    if (pick < 92) return $urandom_range(9, 24);
    return $urandom_range(big_lo, big_hi);
  endfunction

  // mostly small Q4.4 taps so the sums land inside 0..255
  function automatic logic [COEF_REG_W-1:0] rand_coef_row();
    logic [COEF_REG_W-1:0] taps;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: taps[8*k +: 8] = 8'h00;
        1: taps[8*k +: 8] = 8'($urandom_range(255));
        default: taps[8*k +: 8] = 8'(int'($urandom_range(32)) - 16);
      endcase
    end
    return taps;
  endfunction

  task automatic convolve_pixel(input pix_t p);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    pix_t        above2;
    pix_t        above1;
    int          acc;
    int unsigned level;
    bit          interior;
    bit          on_border;
    w = clip_size(width_reg, MAX_W);
    h = clip_size(height_reg, MAX_H);
    x = col_cnt;
    y = row_cnt;
    above2 = line_old[x];
    above1 = line_new[x];
    line_old[x] = above1;
    line_new[x] = p;
    if (col_hits[x] != 2'd2) col_hits[x]++;
    for (int k = 0; k < 3; k++) begin
      window[3*k]   = window[3*k+1];
      window[3*k+1] = window[3*k+2];
    end
    window[2] = above2;
    window[5] = above1;
    window[8] = p;
    interior  = (x >= 2 && y >= 2);
    on_border = (x == 0 || x >= w - 1 || y == 0 || y >= h - 1);
    if (interior) begin
      acc = 0;
      for (int k = 0; k < 9; k++) begin
        acc += int'(window[k]) * int'($signed(kernel_rows[k/3][8*(k%3) +: 8]));
      end
      if (acc < 0) level = 0;
      else if ((acc >>> 4) > 255) level = 255;
      else level = acc >>> 4;
      pending_results.push_back(result_t'{col: 10'(x - 1), row: 12'(y - 1),
                                          pix: pix_t'(level), last: !on_border});
    end
    if (on_border) begin
      pending_results.push_back(result_t'{col: 10'(x), row: 12'(y), pix: p, last: 1'b1});
    end
    if (x >= w - 1) begin
      col_cnt = 0;
      row_cnt = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  // valid stays high across back-to-back transfers; in this task only the gap loop lowers it
  task automatic send_pixel(input pix_t value);
    while ($urandom_range(99) < src_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= value;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    convolve_pixel(value);
  endtask

  // hold the stream until every expected pixel is out, plus pipeline slack
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg      = value[IMG_W_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg     = value[IMG_H_REG_W-1:0];
      REG_COEF_TOP:     kernel_rows[0] = value;
      REG_COEF_MIDDLE:  kernel_rows[1] = value;
      REG_COEF_BOTTOM:  kernel_rows[2] = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // reset geometry and identity kernel, then width and height cut mid-frame
  task automatic test_reset_defaults();
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h80);
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd3);
    send_pixel(8'h01);  // column 3 is past the new last column: right border, row ends
    for (int i = 0; i < 5; i++) send_pixel(rand_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    send_pixel(8'h7E);
  endtask

  // all-max taps saturate at 255, all-min taps clamp to 0
  task automatic test_coef_extremes();
    settle();
    write_reg(REG_IMAGE_HEIGHT, 24'd4);
    write_reg(REG_COEF_TOP, 24'h7F7F7F);
    write_reg(REG_COEF_MIDDLE, 24'h7F7F7F);
    write_reg(REG_COEF_BOTTOM, 24'h7F7F7F);
    repeat (9) send_pixel(pix_t'($urandom_range(1, 255)));
    settle();
    write_reg(REG_COEF_TOP, 24'h808080);
    write_reg(REG_COEF_MIDDLE, 24'h808080);
    write_reg(REG_COEF_BOTTOM, 24'h808080);
    repeat (3) send_pixel(pix_t'($urandom_range(1, 255)));
  endtask

  // sizes above the maximum saturate, zero sizes act as one
  task automatic test_size_limits();
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd2047);
    write_reg(REG_IMAGE_HEIGHT, 24'd8191);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd0);
    write_reg(REG_IMAGE_HEIGHT, 24'd0);
    send_pixel(8'h5A);  // ends row and frame
    send_pixel(8'hA5);  // one-pixel frame
  endtask

  task automatic test_random_frames(input int unsigned n_pixels);
    int unsigned sent;
    int unsigned burst;
    int unsigned w;
    int unsigned h;
    int unsigned left;
    int unsigned new_w;
    bit          at_start;
    sent = 0;
    while (sent < n_pixels) begin
      settle();
      at_start = (col_cnt == 0 && row_cnt == 0);
      w = clip_size(width_reg, MAX_W);
      new_w = rand_size(1024, 2047);
      if (w > 64) begin
        write_reg(REG_IMAGE_WIDTH, 24'($urandom_range(3, 10)));
      end else if ($urandom_range(99) < (at_start ? 70 : 15)) begin
        // mid-frame growth only over columns both line stores already hold
        if (at_start || clip_size(new_w, MAX_W) <= w ||
            columns_filled(clip_size(new_w, MAX_W))) begin
          write_reg(REG_IMAGE_WIDTH, 24'(new_w));
        end
      end
      if ($urandom_range(99) < (at_start ? 70 : 20)) begin
        write_reg(REG_IMAGE_HEIGHT, 24'(rand_size(25, 8191)));
      end
      if ($urandom_range(1) == 1) write_reg(REG_COEF_TOP, rand_coef_row());
      if ($urandom_range(1) == 1) write_reg(REG_COEF_MIDDLE, rand_coef_row());
      if ($urandom_range(1) == 1) write_reg(REG_COEF_BOTTOM, rand_coef_row());
      w = clip_size(width_reg, MAX_W);
      h = clip_size(height_reg, MAX_H);
      left = ((col_cnt >= w - 1) ? 1 : w - col_cnt) +
             ((row_cnt >= h - 1) ? 0 : (h - 1 - row_cnt) * w);
      // mostly finish the frame so deeper rows get exercised
      burst = (left <= 64 && $urandom_range(99) < 70) ? left : $urandom_range(8, 64);
      repeat (burst) send_pixel(rand_pixel());
      sent += burst;
    end
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: col %0d row %0d pixel %0d", res_if.out_col,
               res_if.out_row, res_if.pixel_out);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, res_if.out_col);
          n_errors++;
        end
        if (res_if.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, res_if.out_row);
          n_errors++;
        end
        if (res_if.pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, got %0d", want.pix, res_if.pixel_out);
          n_errors++;
        end
        if (res_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, res_if.last_of_run);
          n_errors++;
        end
      end
    end
  end

  initial begin
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_IMAGE_WIDTH;
    cfg_if.data     <= '0;
    rst_ni          <= 1'b0;
    width_reg      = IMG_W_RESET;
    height_reg     = IMG_H_RESET;
    kernel_rows[0] = COEF_TOP_RESET;
    kernel_rows[1] = COEF_MID_RESET;
    kernel_rows[2] = COEF_BOT_RESET;
    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
      col_hits[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    src_gap_pct    = 38;
    sink_stall_pct = 65;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_coef_extremes();
    test_size_limits();
    test_random_frames(370);
    src_gap_pct    = 65;
    sink_stall_pct = 38;
    test_random_frames(370);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_frames(370);

    settle();
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("conv3x3_border_copy_clamp_unit_tb: done, clean");
    end else begin
      $display("conv3x3_border_copy_clamp_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("conv3x3_border_copy_clamp_unit_tb: done, errors");
    $finish;
  end

endmodule
